[hw/rtl/rbmnr_pkg.sv]
// Shared types, constants and helpers for the ROM bank mapper with nibble RAM.
// No dependencies.
`default_nettype none

package rbmnr_pkg;

    // Bus access kinds carried by one item.
    typedef enum logic [1:0] {
        ACT_ROM_RD  = 2'd0,
        ACT_CTRL_WR = 2'd1,
        ACT_RAM_RD  = 2'd2,
        ACT_RAM_WR  = 2'd3
    } t_action;

    localparam int unsigned BANK_W      = 4;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned NIB_W       = 4;
    localparam int unsigned ROM_ADDR_W  = 18;
    localparam int unsigned ROM_OFS_W   = 14;

    localparam logic [COUNT_W-1:0] BANK_COUNT_RST = 5'd16;
    localparam logic [BANK_W-1:0]  BANK_RST       = 4'd1;
    localparam logic [NIB_W-1:0]   RAM_EN_KEY     = 4'hA;
    localparam logic [DATA_W-1:0]  RD_OPEN_BUS    = 8'hFF;
    localparam logic [NIB_W-1:0]   RD_HIGH_NIB    = 4'hF;
    // RAM window 0xA000..0xBFFF is exactly bus_address[15:13] == 3'b101.
    localparam logic [2:0]         RAM_WIN_TAG    = 3'b101;
    localparam int unsigned        CTRL_SEL_BIT   = 8;

    // Remainder of a 4-bit value by a 5-bit count, restoring long division,
    // one bit per step. A count of zero acts as one.
    function automatic logic [BANK_W-1:0] bank_mod(input logic [BANK_W-1:0]  num,
                                                    input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W:0] den;
        logic [COUNT_W:0] rem;
        den = (cnt == '0) ? (COUNT_W+1)'(1) : {1'b0, cnt};
        rem = '0;
        for (int i = BANK_W - 1; i >= 0; i--) begin
            rem = {rem[COUNT_W-1:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
            end
        end
        return rem[BANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rom_bank_mapper_nibble_ram_top.sv]
// Top level of the cartridge ROM bank mapper with a built-in 512 x 4 nibble RAM.
// Depends on rbmnr_pkg and rbmnr_ram.
// Accept loads stage 1 and the RAM read; stage 1 computes into the output register.
// Throughput: 1 item per cycle unless output stalls, set by the single RAM read port.
// Reset: control state clears at once; then a clearing pass zeroes the RAM,
// all RAM_DEPTH entries, with no item accepted. Config writes are always taken.
`default_nettype none

module rom_bank_mapper_nibble_ram_top #(
    parameter int unsigned RAM_DEPTH = 512
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write channel: bank_count
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rbmnr_pkg::COUNT_W-1:0]      i_cfg_data,
    // input item channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_action,
    input  wire logic [rbmnr_pkg::ADDR_W-1:0]       i_bus_address,
    input  wire logic [rbmnr_pkg::DATA_W-1:0]       i_write_data,
    // result item channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [rbmnr_pkg::ROM_ADDR_W-1:0]   o_rom_byte_address,
    output logic                                    o_rom_address_valid,
    output logic      [rbmnr_pkg::DATA_W-1:0]       o_read_data,
    output logic                                    o_bank_changed
);

    import rbmnr_pkg::*;

    localparam int unsigned IDX_W = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------
    // Architectural state
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] r_bank_count;
    logic [BANK_W-1:0]  r_bank, n_bank;
    logic               r_ram_en, n_ram_en;

    // RAM clearing pass after reset
    logic               r_clr_active;
    logic [IDX_W-1:0]   r_clr_addr;

    // Stage 1: item waits here while its RAM read completes
    logic               r_s1_valid;
    t_action            r_s1_action;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [NIB_W-1:0]   r_s1_nib;
    logic               r_s1_fwd;       // RAM read overlapped a write to the same entry
    logic [NIB_W-1:0]   r_s1_fwd_nib;

    // Output register
    logic                  r_out_valid;
    logic [ROM_ADDR_W-1:0] r_out_rom_addr;
    logic                  r_out_rom_vld;
    logic [DATA_W-1:0]     r_out_rdata;
    logic                  r_out_changed;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic w_s1_fire;
    logic w_in_fire;

    assign w_s1_fire  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clr_active && (!r_s1_valid || w_s1_fire);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Nibble RAM: read issued at accept, write done when stage 1 retires
    // ------------------------------------------------------------------
    logic             w_ram_we;
    logic [IDX_W-1:0] w_ram_waddr;
    logic [NIB_W-1:0] w_ram_wdata;
    logic [NIB_W-1:0] w_ram_rdata;
    logic             w_item_we;      // stage 1 RAM write, valid when it retires
    logic [IDX_W-1:0] w_s1_idx;
    logic [IDX_W-1:0] w_in_idx;

    assign w_s1_idx = r_s1_addr[IDX_W-1:0];
    assign w_in_idx = i_bus_address[IDX_W-1:0];

    always_comb begin
        if (r_clr_active) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_s1_fire && w_item_we;
            w_ram_waddr = w_s1_idx;
            w_ram_wdata = r_s1_nib;
        end
    end

    rbmnr_ram #(
        .WIDTH (NIB_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_in_fire),
        .i_raddr (w_in_idx),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 compute: decode the access against current state
    // ------------------------------------------------------------------
    logic                  w_in_win;
    logic                  w_ram_ok;
    logic [NIB_W-1:0]      w_rd_nib;
    logic [BANK_W-1:0]     w_rom_bank;
    logic [BANK_W-1:0]     w_ld_raw;
    logic [BANK_W-1:0]     w_ld_mod;
    logic [BANK_W-1:0]     w_ld_bank;
    logic                  w_low_area;
    logic [ROM_ADDR_W-1:0] n_out_rom_addr;
    logic                  n_out_rom_vld;
    logic [DATA_W-1:0]     n_out_rdata;
    logic                  n_out_changed;

    assign w_in_win   = (r_s1_addr[ADDR_W-1:ADDR_W-3] == RAM_WIN_TAG);
    assign w_ram_ok   = r_ram_en && w_in_win;
    assign w_rd_nib   = r_s1_fwd ? r_s1_fwd_nib : w_ram_rdata;
    assign w_low_area = (r_s1_addr[ADDR_W-1:ROM_OFS_W] == '0);

    // bank lookups: current bank for ROM reads, loaded nibble for control writes
    assign w_rom_bank = w_low_area ? '0 : bank_mod(r_bank, r_bank_count);
    assign w_ld_raw   = (r_s1_nib == '0) ? BANK_RST : r_s1_nib;
    assign w_ld_mod   = bank_mod(w_ld_raw, r_bank_count);
    assign w_ld_bank  = (w_ld_mod == '0) ? BANK_RST : w_ld_mod;

    always_comb begin
        n_bank         = r_bank;
        n_ram_en       = r_ram_en;
        w_item_we      = 1'b0;
        n_out_rom_addr = '0;
        n_out_rom_vld  = 1'b0;
        n_out_rdata    = '0;
        n_out_changed  = 1'b0;
        unique case (r_s1_action)
            ACT_ROM_RD: begin
                n_out_rom_addr = {w_rom_bank, r_s1_addr[ROM_OFS_W-1:0]};
                n_out_rom_vld  = 1'b1;
            end
            ACT_CTRL_WR: begin
                if (w_low_area) begin
                    if (r_s1_addr[CTRL_SEL_BIT]) begin
                        n_bank        = w_ld_bank;
                        n_out_changed = (w_ld_bank != r_bank);
                    end else begin
                        n_ram_en = (r_s1_nib == RAM_EN_KEY);
                    end
                end
            end
            ACT_RAM_RD: begin
                n_out_rdata = w_ram_ok ? {RD_HIGH_NIB, w_rd_nib} : RD_OPEN_BUS;
            end
            ACT_RAM_WR: begin
                w_item_we = w_ram_ok;
            end
            default: begin
                n_out_rdata = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_count <= BANK_COUNT_RST;
            r_bank       <= BANK_RST;
            r_ram_en     <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_bank_count <= i_cfg_data;
            end
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(RAM_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (w_s1_fire) begin
                r_bank   <= n_bank;
                r_ram_en <= n_ram_en;
            end
            if (w_in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1_action  <= t_action'(i_action);
            r_s1_addr    <= i_bus_address;
            r_s1_nib     <= i_write_data[NIB_W-1:0];
            // write retiring this cycle to the entry being read: RAM returns old data
            r_s1_fwd     <= w_ram_we && (w_ram_waddr == w_in_idx);
            r_s1_fwd_nib <= w_ram_wdata;
        end
        if (w_s1_fire) begin
            r_out_rom_addr <= n_out_rom_addr;
            r_out_rom_vld  <= n_out_rom_vld;
            r_out_rdata    <= n_out_rdata;
            r_out_changed  <= n_out_changed;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_rom_byte_address  = r_out_rom_addr;
    assign o_rom_address_valid = r_out_rom_vld;
    assign o_read_data         = r_out_rdata;
    assign o_bank_changed      = r_out_changed;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a stalled stage 1 must keep its RAM read data
    a_s1_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_fire) |=> $stable(w_ram_rdata))
        else $error("RAM read data changed under a stalled item");

    // the selected bank is never zero
    a_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bank != '0)
        else $error("selected bank is zero");

    // a new result only ever comes from stage 1
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without an item in stage 1");

    // no item reaches stage 1 while the RAM is being cleared
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |=> !$rose(r_s1_valid))
        else $error("item accepted during RAM clearing pass");

endmodule

`default_nettype wire

[hw/rtl/rbmnr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module rbmnr_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[dv/tb_rom_bank_mapper_nibble_ram_top.sv]
// Self-checking testbench for rom_bank_mapper_nibble_ram_top: bus accesses in,
// mapped ROM addresses, RAM read data and bank-change flags out.
// Depends on rbmnr_pkg and the mapper RTL.
`default_nettype none

module tb_rom_bank_mapper_nibble_ram_top;
    import rbmnr_pkg::*;

    // One result item as the block presents it.
    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_byte_address;
        logic                  rom_address_valid;
        logic [DATA_W-1:0]     read_data;
        logic                  bank_changed;
    } t_map_result;

    // Mirror of the mapper state. Each accepted access is predicted on the
    // spot and its result queued; results from the block are checked in order.
    class t_mapper_predictor;
        logic [COUNT_W-1:0] bank_count;
        logic [BANK_W-1:0]  cur_bank;
        logic               ram_on;
        logic [NIB_W-1:0]   nib_store [512];
        t_map_result        expected_results [$];
        int unsigned        mismatches;

        function new();
            bank_count = BANK_COUNT_RST;
            cur_bank   = BANK_RST;
            ram_on     = 1'b0;
            foreach (nib_store[i]) nib_store[i] = '0;
            mismatches = 0;
        endfunction

        function void set_bank_count(logic [COUNT_W-1:0] val);
            bank_count = val;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void take_access(t_action act, logic [ADDR_W-1:0] addr,
                                  logic [DATA_W-1:0] data);
            t_map_result res;
            int          modulus;
            int          bank;
            logic        in_win;
            res     = '0;
            modulus = (bank_count == 0) ? 1 : int'(bank_count);
            in_win  = (addr >= 16'hA000) && (addr <= 16'hBFFF);
            case (act)
                ACT_ROM_RD: begin
                    bank = (addr > 16'h3FFF) ? (int'(cur_bank) % modulus) : 0;
                    res.rom_byte_address  = ROM_ADDR_W'(bank * 'h4000 + int'(addr[13:0]));
                    res.rom_address_valid = 1'b1;
                end
                ACT_CTRL_WR: begin
                    if (addr <= 16'h3FFF) begin
                        if (addr[CTRL_SEL_BIT]) begin
                            bank = (data[3:0] == 0) ? 1 : int'(data[3:0]);
                            bank = bank % modulus;
                            if (bank == 0) bank = 1;
                            if (BANK_W'(bank) != cur_bank) begin
                                cur_bank         = BANK_W'(bank);
                                res.bank_changed = 1'b1;
                            end
                        end else begin
                            ram_on = (data[3:0] == RAM_EN_KEY);
                        end
                    end
                end
                ACT_RAM_RD: begin
                    res.read_data = (ram_on && in_win) ? {RD_HIGH_NIB, nib_store[addr[8:0]]}
                                                       : RD_OPEN_BUS;
                end
                ACT_RAM_WR: begin
                    if (ram_on && in_win) nib_store[addr[8:0]] = data[3:0];
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void report(string field, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(t_map_result got);
            t_map_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual 0x%0h", $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.rom_byte_address !== want.rom_byte_address)
                report("rom_byte_address", want.rom_byte_address, got.rom_byte_address);
            if (got.rom_address_valid !== want.rom_address_valid)
                report("rom_address_valid", want.rom_address_valid, got.rom_address_valid);
            if (got.read_data !== want.read_data)
                report("read_data", want.read_data, got.read_data);
            if (got.bank_changed !== want.bank_changed)
                report("bank_changed", want.bank_changed, got.bank_changed);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [COUNT_W-1:0]    i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_action;
    logic [ADDR_W-1:0]     i_bus_address;
    logic [DATA_W-1:0]     i_write_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ROM_ADDR_W-1:0] o_rom_byte_address;
    logic                  o_rom_address_valid;
    logic [DATA_W-1:0]     o_read_data;
    logic                  o_bank_changed;

    // Shared knobs: random idling on/off, and a one-shot request for the
    // sink to hold off long enough that the block backs up into its input.
    bit gaps_on   = 1'b0;
    bit want_hold = 1'b0;

    t_mapper_predictor model = new();

    rom_bank_mapper_nibble_ram_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_bus_address       (i_bus_address),
        .i_write_data        (i_write_data),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_rom_byte_address  (o_rom_byte_address),
        .o_rom_address_valid (o_rom_address_valid),
        .o_read_data         (o_read_data),
        .o_bank_changed      (o_bank_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop; far beyond the slowest legal run (reset clear pass, every
    // item waiting out the worst gaps and the long hold-off).
    initial begin
        #2_000_000;
        $display("tb_rom_bank_mapper_nibble_ram_top failed");
        $finish;
    end

    // Handshake monitor. Everything is sampled at the edge, so the values
    // seen are the ones settled before it; TB drives land after.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) model.set_bank_count(i_cfg_data);
            if (i_in_valid && o_in_ready)
                model.take_access(t_action'(i_action), i_bus_address, i_write_data);
            if (o_out_valid && i_out_ready)
                model.check_result({o_rom_byte_address, o_rom_address_valid,
                                    o_read_data, o_bank_changed});
        end
    end

    // Result sink: random back-pressure, plus one long hold-off on request.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold) begin
                want_hold = 1'b0;
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(99) < 20);
            end
        end
    end

    // Offer one item; returns at the edge where it is taken. An optional
    // idle gap goes first so valid never drops while an item is pending.
    task automatic send_access(input t_action act, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        if (gaps_on && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_bus_address <= addr;
        i_write_data  <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: control writes land in the control range
    // and keep RAM enabled most of the time, RAM accesses mostly hit the
    // window and a handful of entries so reads see earlier writes.
    task automatic send_random_access();
        int                pick;
        t_action           act;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(99);
        data = DATA_W'($urandom_range(255));
        addr = ADDR_W'($urandom_range(65535));
        if (pick < 25) begin
            act = ACT_ROM_RD;
        end else if (pick < 45) begin
            act = ACT_CTRL_WR;
            if ($urandom_range(9) != 0) addr[15:14] = 2'b00;
            if (!addr[CTRL_SEL_BIT] && $urandom_range(9) < 7) data[3:0] = RAM_EN_KEY;
        end else begin
            act = (pick < 75) ? ACT_RAM_RD : ACT_RAM_WR;
            if ($urandom_range(99) < 85) begin
                addr[15:13] = RAM_WIN_TAG;
                if ($urandom_range(9) < 7) addr[8:0] = 9'($urandom_range(15));
            end
        end
        send_access(act, addr, data);
    endtask

    task automatic write_bank_count(input logic [COUNT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every predicted result, then let stage 1 and the output
    // register empty before the block counts as idle. The first edge
    // lets the monitor note an item taken at the edge this is called on.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (model.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        logic [COUNT_W-1:0] counts [11];
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_ROM_RD;
        i_bus_address <= '0;
        i_write_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The RAM clear pass after reset simply holds in_ready low.

        // Directed part, reset bank count of 16, no idling.
        send_access(ACT_ROM_RD,  16'h0000, 8'h00);  // fixed bank 0
        send_access(ACT_ROM_RD,  16'h3FFF, 8'hFF);
        send_access(ACT_ROM_RD,  16'h4000, 8'h00);  // reset bank 1
        send_access(ACT_ROM_RD,  16'hFFFF, 8'h00);
        send_access(ACT_RAM_RD,  16'hA000, 8'h00);  // RAM still disabled
        send_access(ACT_RAM_WR,  16'hA005, 8'h07);  // dropped, disabled
        send_access(ACT_CTRL_WR, 16'h0000, 8'h0A);  // enable
        send_access(ACT_RAM_RD,  16'hA005, 8'h00);
        send_access(ACT_RAM_WR,  16'hA1FF, 8'h5C);  // top entry
        send_access(ACT_RAM_RD,  16'hBFFF, 8'h00);  // window end, same entry
        send_access(ACT_RAM_RD,  16'h9FFF, 8'h00);  // just below window
        send_access(ACT_RAM_WR,  16'hC000, 8'h03);  // just above window
        send_access(ACT_RAM_RD,  16'hC000, 8'h00);
        send_access(ACT_CTRL_WR, 16'h0100, 8'h00);  // bank zero -> 1, no change
        send_access(ACT_CTRL_WR, 16'h3FFF, 8'hFF);  // bank 15
        send_access(ACT_ROM_RD,  16'h7ABC, 8'h00);
        send_access(ACT_CTRL_WR, 16'h4100, 8'h03);  // above control range
        send_access(ACT_CTRL_WR, 16'h0100, 8'h10);  // zero nibble -> bank 1
        send_access(ACT_CTRL_WR, 16'h00FF, 8'h0B);  // disable
        send_access(ACT_RAM_RD,  16'hA1FF, 8'h00);
        send_access(ACT_RAM_WR,  16'hFFFF, 8'hFF);
        send_access(ACT_CTRL_WR, 16'h0000, 8'hFA);  // enable, upper nibble ignored
        send_access(ACT_RAM_RD,  16'hBE05, 8'h00);  // aliases entry 5
        wait_drained();

        // Random phases, each under its own bank count: the reset value,
        // the extremes (zero and above sixteen included) and a few others.
        counts = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd3, 5'd0, 5'd15, 5'd17, 5'd9, 5'd16};
        counts[6] = COUNT_W'($urandom_range(31));
        foreach (counts[p]) begin
            write_bank_count(counts[p]);
            gaps_on = (p != 4);         // one long stretch with no idling
            if (p == 6) want_hold = 1'b1;
            repeat (160) send_random_access();
            wait_drained();
        end

        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("tb_rom_bank_mapper_nibble_ram_top passed");
        end else begin
            $display("tb_rom_bank_mapper_nibble_ram_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
